@@ rtl/pbcm_pkg.sv @@
// pbcm_pkg: shared constants and codes for the position base-call metrics block
// depends on nothing; used by every module under rtl except pbcm_div_lane
package pbcm_pkg;

   localparam int CLASS_COUNT = 5;
   localparam int BASE_W = 3;
   localparam int LOG_STEPS = 32;
   localparam int LOG_W = 32;
   localparam logic [LOG_W-1:0] LN2_Q32 = 32'hB17217F8;
   // leading-one stage, squaring stages, then four multiply/round stages
   localparam int ENT_LAT = 1 + LOG_STEPS + 4;

   typedef enum logic [BASE_W-1:0] {
      BASE_A   = 3'd0,
      BASE_C   = 3'd1,
      BASE_G   = 3'd2,
      BASE_T   = 3'd3,
      BASE_GAP = 3'd4
   } base_code_type;

   localparam int GAP_CLASS = int'(BASE_GAP);

endpackage

@@ rtl/pbcm_div_lane.sv @@
// pbcm_div_lane: pipelined restoring divider, floor(num * 2^(Q_W-1) / den), num <= den
// one quotient bit per stage; depends on nothing but its parameters
module pbcm_div_lane #(
   parameter int NUM_W = 27,
   parameter int Q_W = 17
) (
   input  logic             clock,
   input  logic             ce,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic [Q_W-1:0]   quot
);

   logic [NUM_W-1:0] r_ff [Q_W];
   logic [NUM_W-1:0] d_ff [Q_W];
   logic [Q_W-1:0]   q_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic [NUM_W:0]   trial;
      logic [NUM_W-1:0] dv;
      logic [Q_W-1:0]   qp;
      logic             ge;
      logic [NUM_W-1:0] r_in;
      logic [Q_W-1:0]   q_in;

      if (s == 0) begin : g_first
         always_comb begin
            trial = {1'b0, num};
            dv = den;
            qp = '0;
         end
      end else begin : g_next
         always_comb begin
            trial = {r_ff[s-1], 1'b0};
            dv = d_ff[s-1];
            qp = q_ff[s-1];
         end
      end

      always_comb begin
         ge = trial >= {1'b0, dv};
         r_in = ge ? NUM_W'(trial - {1'b0, dv}) : NUM_W'(trial);
         q_in = {qp[Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            r_ff[s] <= r_in;
            d_ff[s] <= dv;
            q_ff[s] <= q_in;
         end
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule

@@ rtl/pbcm_ent_lane.sv @@
// pbcm_ent_lane: one entropy term round(-x ln x) in Q(FRAC_BITS) for x = p / 2^FRAC_BITS
// pipelined log2 by repeated squaring then ln2 scaling; depends on pbcm_pkg
module pbcm_ent_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 ce,
   input  logic [FRAC_BITS-1:0] p,
   output logic [FRAC_BITS-1:0] term
);

   localparam int EW = $clog2(FRAC_BITS + 1);
   localparam int LW = pbcm_pkg::LOG_W;
   localparam int NS = pbcm_pkg::LOG_STEPS;
   localparam int AW = FRAC_BITS + EW + LW;
   localparam int HW = FRAC_BITS + EW;

   // leading-one normalize
   logic [EW-1:0] e_val;
   logic [LW-1:0] m_in;

   always_comb begin
      e_val = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (p[i]) begin
            e_val = EW'(i);
         end
      end
      m_in = LW'(p) << (LW - 1 - int'(e_val));
   end

   logic [LW-1:0]        m_ff [NS+1];
   logic [LW-1:0]        f_ff [NS+1];
   logic [EW-1:0]        k_ff [NS+1];
   logic [FRAC_BITS-1:0] p_ff [NS+1];
   logic                 nz_ff [NS+4];

   always_ff @(posedge clock) begin
      if (ce) begin
         m_ff[0] <= m_in;
         f_ff[0] <= '0;
         k_ff[0] <= EW'(FRAC_BITS) - e_val;
         p_ff[0] <= p;
         nz_ff[0] <= |p;
         for (int i = 1; i < NS + 4; i++) begin
            nz_ff[i] <= nz_ff[i-1];
         end
      end
   end

   // m stays in [2^31, 2^32); each step yields one fraction bit of log2
   for (genvar s = 1; s <= NS; s++) begin : g_sq
      logic [2*LW-1:0] sq;
      logic [LW:0]     t;
      logic [LW-1:0]   m_in_s;
      logic [LW-1:0]   f_in_s;

      always_comb begin
         sq = m_ff[s-1] * m_ff[s-1];
         t = sq[2*LW-1:LW-1];
         if (t[LW]) begin
            m_in_s = t[LW:1];
            f_in_s = {f_ff[s-1][LW-2:0], 1'b1};
         end else begin
            m_in_s = t[LW-1:0];
            f_in_s = {f_ff[s-1][LW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            m_ff[s] <= m_in_s;
            f_ff[s] <= f_in_s;
            k_ff[s] <= k_ff[s-1];
            p_ff[s] <= p_ff[s-1];
         end
      end
   end

   // p * (k * 2^32 - f), then times ln2
   logic [FRAC_BITS+EW-1:0] pk_ff;
   logic [FRAC_BITS+LW-1:0] pf_ff;
   logic [AW-1:0]           a_ff;
   logic [HW+LW-1:0]        x1_ff;
   logic [2*LW-1:0]         x2_ff;
   logic [FRAC_BITS-1:0]    term_ff;
   logic [AW-1:0]           a_in;
   logic [HW+LW:0]          s_sum;

   always_comb begin
      a_in = (AW'(pk_ff) << LW) - AW'(pf_ff);
      s_sum = (HW+LW+1)'(x1_ff) + (HW+LW+1)'(x2_ff[2*LW-1:LW])
            + ((HW+LW+1)'(1) << (LW - 1));
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pk_ff <= p_ff[NS] * k_ff[NS];
         pf_ff <= p_ff[NS] * f_ff[NS];
         a_ff <= a_in;
         x1_ff <= a_ff[AW-1:LW] * pbcm_pkg::LN2_Q32;
         x2_ff <= a_ff[LW-1:0] * pbcm_pkg::LN2_Q32;
         term_ff <= nz_ff[NS+3] ? s_sum[FRAC_BITS+LW-1:LW] : '0;
      end
   end

   assign term = term_ff;

endmodule

@@ rtl/pbcm_merge.sv @@
// pbcm_merge: sums the lane entropy terms, packs the result and holds it in a skid output
// depends on pbcm_pkg
module pbcm_merge #(
   parameter int TW = 27,
   parameter int RW = 17,
   parameter int OUT_W = 104
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       pipe_valid,
   input  logic [TW-1:0]                              total,
   input  logic [pbcm_pkg::BASE_W-1:0]                base,
   input  logic                                       single,
   input  logic [RW-1:0]                              del_rate,
   input  logic [RW-1:0]                              mis_rate,
   input  logic [RW-1:0]                              chg_rate,
   input  logic [pbcm_pkg::CLASS_COUNT-1:0][RW-2:0]   terms,
   output logic                                       ce,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [OUT_W-1:0]                           rsp_tdata
);

   logic [RW-1:0]    ent_sum;
   logic [OUT_W-1:0] push_data;
   logic             push;
   logic             pop;

   logic             out_valid_ff, out_valid_in;
   logic [OUT_W-1:0] out_data_ff, out_data_in;
   logic             spare_valid_ff, spare_valid_in;
   logic [OUT_W-1:0] spare_data_ff, spare_data_in;

   always_comb begin
      ent_sum = '0;
      for (int i = 0; i < pbcm_pkg::CLASS_COUNT; i++) begin
         ent_sum = ent_sum + RW'(terms[i]);
      end
      // one class holding every read has zero entropy
      if (single) begin
         ent_sum = '0;
      end
      push_data = OUT_W'({ent_sum, chg_rate, mis_rate, del_rate, base, total});
   end

   assign ce = !spare_valid_ff;
   assign push = pipe_valid && ce;
   assign pop = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      spare_valid_in = spare_valid_ff;
      spare_data_in = spare_data_ff;
      if (pop) begin
         out_valid_in = spare_valid_ff || push;
         out_data_in = spare_valid_ff ? spare_data_ff : push_data;
         spare_valid_in = 1'b0;
      end else if (push) begin
         spare_valid_in = 1'b1;
         spare_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

endmodule

@@ rtl/position_base_call_metrics.sv @@
// position_base_call_metrics: per-position read totals, rates and Shannon entropy
// depends on pbcm_pkg, pbcm_div_lane, pbcm_ent_lane, pbcm_merge
//
//  channel  | dir | handshake          | payload
//  req      | in  | req_tvalid/tready  | five counts and reference base
//  rsp      | out | rsp_tvalid/tready  | total, base, three rates, entropy
//
// one request per cycle sustained while the skid spare is empty; the path to the output
// register runs through the divider lanes and the 32 log squaring stages
// a request whose counts are all zero gives no response
// reset clears the valid bits of every stage and of the output skid
// a stalled response is held; the pipeline stops only once the skid spare is full
module position_base_call_metrics #(
   parameter int COUNT_WIDTH = 24,
   parameter int FRAC_BITS = 16,
   localparam int IN_W = ((pbcm_pkg::CLASS_COUNT * COUNT_WIDTH + pbcm_pkg::BASE_W + 7) / 8) * 8,
   localparam int OUT_W = ((COUNT_WIDTH + 3 + pbcm_pkg::BASE_W + 4 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // count_a, count_c, count_g, count_t, count_gap, ref_base
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // total_reads, base_type, deletion_rate, mismatch_rate, change_rate, entropy
   output logic [OUT_W-1:0] rsp_tdata
);

   localparam int CW = COUNT_WIDTH;
   localparam int NC = pbcm_pkg::CLASS_COUNT;
   localparam int BW = pbcm_pkg::BASE_W;
   localparam int TW = CW + 3;
   localparam int RW = FRAC_BITS + 1;
   localparam int NDIV = NC + 2;
   localparam int DIV_LAT = RW;
   localparam int ENT_LAT = pbcm_pkg::ENT_LAT;
   localparam int META_LAT = DIV_LAT + ENT_LAT;
   localparam int META_W = TW + BW + 1;

   logic ce;

   logic [NC-1:0][CW-1:0] cnt_in;
   logic [BW-1:0]         base_in;

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         cnt_in[i] = req_tdata[i*CW +: CW];
      end
      base_in = req_tdata[NC*CW +: BW];
   end

   assign req_tready = ce;

   // stage 1: capture
   logic                  v1_ff;
   logic [NC-1:0][CW-1:0] cnt1_ff;
   logic [BW-1:0]         base1_ff;

   // stage 2: total, reference count, single-class flag
   logic                  v2_ff;
   logic [NC-1:0][CW-1:0] cnt2_ff;
   logic [BW-1:0]         base2_ff;
   logic [TW-1:0]         total2_ff, total2_in;
   logic [CW-1:0]         refc2_ff, refc2_in;
   logic                  single2_ff, single2_in;
   logic [NC-1:0]         nz;

   always_comb begin
      total2_in = '0;
      for (int i = 0; i < NC; i++) begin
         total2_in = total2_in + TW'(cnt1_ff[i]);
         nz[i] = |cnt1_ff[i];
      end
      single2_in = (nz & (nz - NC'(1))) == '0;
      unique case (base1_ff)
         pbcm_pkg::BASE_A:   refc2_in = cnt1_ff[pbcm_pkg::BASE_A];
         pbcm_pkg::BASE_C:   refc2_in = cnt1_ff[pbcm_pkg::BASE_C];
         pbcm_pkg::BASE_G:   refc2_in = cnt1_ff[pbcm_pkg::BASE_G];
         pbcm_pkg::BASE_T:   refc2_in = cnt1_ff[pbcm_pkg::BASE_T];
         pbcm_pkg::BASE_GAP: refc2_in = cnt1_ff[pbcm_pkg::BASE_GAP];
         default:            refc2_in = '0;
      endcase
   end

   // stage 3: mismatch and change numerators
   logic                  v3_ff;
   logic [NC-1:0][CW-1:0] cnt3_ff;
   logic [BW-1:0]         base3_ff;
   logic [TW-1:0]         total3_ff;
   logic                  single3_ff;
   logic [TW-1:0]         mis3_ff, mis3_in;
   logic [TW-1:0]         chg3_ff;
   logic [CW:0]           ref_gap;

   always_comb begin
      ref_gap = (CW+1)'(refc2_ff) + (CW+1)'(cnt2_ff[pbcm_pkg::GAP_CLASS]);
      // a gap reference can push this below zero; clamp
      mis3_in = (total2_ff >= TW'(ref_gap)) ? total2_ff - TW'(ref_gap) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= req_tvalid && (|cnt_in);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         cnt1_ff <= cnt_in;
         base1_ff <= base_in;
         cnt2_ff <= cnt1_ff;
         base2_ff <= base1_ff;
         total2_ff <= total2_in;
         refc2_ff <= refc2_in;
         single2_ff <= single2_in;
         cnt3_ff <= cnt2_ff;
         base3_ff <= base2_ff;
         total3_ff <= total2_ff;
         single3_ff <= single2_ff;
         mis3_ff <= mis3_in;
         chg3_ff <= total2_ff - TW'(refc2_ff);
      end
   end

   // divider lanes: five class shares, then mismatch and change
   logic [NDIV-1:0][TW-1:0] div_num;
   logic [NDIV-1:0][RW-1:0] div_q;

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         div_num[i] = TW'(cnt3_ff[i]);
      end
      div_num[NC] = mis3_ff;
      div_num[NC+1] = chg3_ff;
   end

   for (genvar i = 0; i < NDIV; i++) begin : g_div
      pbcm_div_lane #(
         .NUM_W (TW),
         .Q_W   (RW)
      ) u_div (
         .clock (clock),
         .ce    (ce),
         .num   (div_num[i]),
         .den   (total3_ff),
         .quot  (div_q[i])
      );
   end

   // entropy lanes; a share of exactly one only occurs with a single class
   logic [NC-1:0][FRAC_BITS-1:0] terms;

   for (genvar i = 0; i < NC; i++) begin : g_ent
      pbcm_ent_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_ent (
         .clock (clock),
         .ce    (ce),
         .p     (div_q[i][FRAC_BITS-1:0]),
         .term  (terms[i])
      );
   end

   // rate delay to meet the entropy terms
   logic [3*RW-1:0] rate_dl_ff [ENT_LAT];

   always_ff @(posedge clock) begin
      if (ce) begin
         rate_dl_ff[0] <= {div_q[NC+1], div_q[NC], div_q[pbcm_pkg::GAP_CLASS]};
         for (int i = 1; i < ENT_LAT; i++) begin
            rate_dl_ff[i] <= rate_dl_ff[i-1];
         end
      end
   end

   // side data delay
   logic [META_W-1:0] meta_dl_ff [META_LAT];
   logic              vld_dl_ff [META_LAT];

   always_ff @(posedge clock) begin
      if (ce) begin
         meta_dl_ff[0] <= {single3_ff, base3_ff, total3_ff};
         for (int i = 1; i < META_LAT; i++) begin
            meta_dl_ff[i] <= meta_dl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < META_LAT; i++) begin
            vld_dl_ff[i] <= 1'b0;
         end
      end else if (ce) begin
         vld_dl_ff[0] <= v3_ff;
         for (int i = 1; i < META_LAT; i++) begin
            vld_dl_ff[i] <= vld_dl_ff[i-1];
         end
      end
   end

   logic [META_W-1:0] meta_out;
   logic [3*RW-1:0]   rate_out;

   assign meta_out = meta_dl_ff[META_LAT-1];
   assign rate_out = rate_dl_ff[ENT_LAT-1];

   pbcm_merge #(
      .TW    (TW),
      .RW    (RW),
      .OUT_W (OUT_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .pipe_valid (vld_dl_ff[META_LAT-1]),
      .total      (meta_out[TW-1:0]),
      .base       (meta_out[TW +: BW]),
      .single     (meta_out[META_W-1]),
      .del_rate   (rate_out[RW-1:0]),
      .mis_rate   (rate_out[RW +: RW]),
      .chg_rate   (rate_out[2*RW +: RW]),
      .terms      (terms),
      .ce         (ce),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/pbcm_checker.sv @@
// pbcm_checker: port-level checks for position_base_call_metrics, bound to the top level
// depends on pbcm_pkg
module pbcm_checker #(
   parameter int COUNT_WIDTH = 24,
   parameter int FRAC_BITS = 16,
   parameter int IN_W = 128,
   parameter int OUT_W = 104
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [IN_W-1:0]  req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata
);

   localparam int TW = COUNT_WIDTH + 3;
   localparam int RW = FRAC_BITS + 1;
   localparam int DEL_LO = TW + pbcm_pkg::BASE_W;
   localparam int MIS_LO = DEL_LO + RW;
   localparam int CHG_LO = MIS_LO + RW;

   logic [RW-1:0] del_r, mis_r, chg_r;
   logic          req_seen;

   assign del_r = rsp_tdata[DEL_LO +: RW];
   assign mis_r = rsp_tdata[MIS_LO +: RW];
   assign chg_r = rsp_tdata[CHG_LO +: RW];
   assign req_seen = req_tvalid && (req_tdata != '0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no response waiting");

   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[TW-1:0] != '0) && (chg_r >= mis_r)
                     && (del_r <= (RW'(1) << FRAC_BITS)) && (req_seen || !req_seen))
      else $error("response fields inconsistent");

endmodule

bind position_base_call_metrics pbcm_checker #(
   .COUNT_WIDTH (COUNT_WIDTH),
   .FRAC_BITS   (FRAC_BITS),
   .IN_W        (IN_W),
   .OUT_W       (OUT_W)
) u_pbcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/tb_position_base_call_metrics.sv @@
// tb_position_base_call_metrics: self-checking bench for the per-position base-call metrics
// depends on pbcm_pkg and position_base_call_metrics; predicts totals, rates and entropy
`timescale 1ns / 100ps

module tb_position_base_call_metrics;

   localparam int CW = 24;
   localparam int FB = 16;
   localparam int IN_W = ((pbcm_pkg::CLASS_COUNT * CW + pbcm_pkg::BASE_W + 7) / 8) * 8;
   localparam int OUT_W = ((CW + 3 + pbcm_pkg::BASE_W + 4 * (FB + 1) + 7) / 8) * 8;
   localparam int PIPE_LAT = 3 + (FB + 1) + pbcm_pkg::ENT_LAT;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [2:0]  ref_base;
      logic [23:0] count_gap;
      logic [23:0] count_t;
      logic [23:0] count_g;
      logic [23:0] count_c;
      logic [23:0] count_a;
   } position_counts_type;

   typedef struct packed {
      logic [16:0] entropy;
      logic [16:0] change_rate;
      logic [16:0] mismatch_rate;
      logic [16:0] deletion_rate;
      logic [2:0]  base_type;
      logic [26:0] total_reads;
   } call_metrics_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;

   call_metrics_type metrics_due[$];
   int errors = 0;
   longint cycles = 0;
   bit stall_enable = 1'b1;

   position_base_call_metrics u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // q1.16 truncating ratio
   function automatic logic [16:0] frac_of(longint unsigned num, longint unsigned total);
      return 17'((num << FB) / total);
   endfunction

   // log2 of m / 2^31 in q32 by repeated squaring
   function automatic longint unsigned log2_frac(longint unsigned m);
      longint unsigned f = 0;
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         f = f << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            f = f | 1;
         end
      end
      return f;
   endfunction

   // -p ln p rounded, p in q16
   function automatic longint unsigned plogp(longint unsigned p);
      int e = 0;
      longint unsigned nl2, a, hi, lo, s;
      for (int i = 0; i < FB; i++)
         if (p[i]) e = i;
      nl2 = (longint'(FB - e) << 32) - log2_frac(p << (31 - e));
      a = p * nl2;
      hi = a >> 32;
      lo = a & 64'hFFFFFFFF;
      s = hi * longint'(pbcm_pkg::LN2_Q32) + ((lo * longint'(pbcm_pkg::LN2_Q32)) >> 32);
      return (s + (64'd1 << 31)) >> 32;
   endfunction

   function automatic bit predict_metrics(position_counts_type pc, output call_metrics_type m);
      longint unsigned c[pbcm_pkg::CLASS_COUNT];
      longint unsigned total = 0, maxc = 0, refc = 0, ent = 0, mis, p;
      c[0] = pc.count_a; c[1] = pc.count_c; c[2] = pc.count_g;
      c[3] = pc.count_t; c[4] = pc.count_gap;
      for (int i = 0; i < pbcm_pkg::CLASS_COUNT; i++) begin
         total += c[i];
         if (c[i] > maxc) maxc = c[i];
      end
      m = '0;
      if (total == 0) return 1'b0;
      if (pc.ref_base < pbcm_pkg::CLASS_COUNT) refc = c[pc.ref_base];
      if (maxc != total)
         for (int i = 0; i < pbcm_pkg::CLASS_COUNT; i++) begin
            p = (c[i] << FB) / total;
            if (p != 0) ent += plogp(p);
         end
      mis = (total >= refc + c[pbcm_pkg::GAP_CLASS]) ?
            total - refc - c[pbcm_pkg::GAP_CLASS] : 0;
      m.total_reads = 27'(total);
      m.base_type = pc.ref_base;
      m.deletion_rate = frac_of(c[pbcm_pkg::GAP_CLASS], total);
      m.mismatch_rate = frac_of(mis, total);
      m.change_rate = frac_of(total - refc, total);
      m.entropy = 17'(ent);
      return 1'b1;
   endfunction

   // response checker with its own stall pattern
   always @(posedge clock) begin
      call_metrics_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = call_metrics_type'(rsp_tdata[$bits(call_metrics_type)-1:0]);
         if (metrics_due.size() == 0) begin
            $error("unexpected response %h", got);
            errors++;
         end else begin
            want = metrics_due.pop_front();
            if (got.total_reads !== want.total_reads) begin
               $error("total_reads exp %0d got %0d", want.total_reads, got.total_reads);
               errors++;
            end
            if (got.base_type !== want.base_type) begin
               $error("base_type exp %0d got %0d", want.base_type, got.base_type);
               errors++;
            end
            if (got.deletion_rate !== want.deletion_rate) begin
               $error("deletion_rate exp %0d got %0d", want.deletion_rate, got.deletion_rate);
               errors++;
            end
            if (got.mismatch_rate !== want.mismatch_rate) begin
               $error("mismatch_rate exp %0d got %0d", want.mismatch_rate, got.mismatch_rate);
               errors++;
            end
            if (got.change_rate !== want.change_rate) begin
               $error("change_rate exp %0d got %0d", want.change_rate, got.change_rate);
               errors++;
            end
            if (got.entropy !== want.entropy) begin
               $error("entropy exp %0d got %0d", want.entropy, got.entropy);
               errors++;
            end
         end
      end
      // stall in stretches; long runs with no stall when phase bit is set
      if (!stall_enable || cycles[9]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   int burst_left = 0;

   // send one request; bursts with random gaps between them
   task automatic send_counts(position_counts_type pc);
      call_metrics_type m;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tdata <= IN_W'(pc);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_metrics(pc, m)) metrics_due.push_back(m);
      burst_left--;
   endtask

   function automatic logic [23:0] rand_count();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(0, 15));
         3: return 24'($urandom_range(0, 1000));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic position_counts_type mk(logic [23:0] a, logic [23:0] c, logic [23:0] g,
                                              logic [23:0] t, logic [23:0] d, logic [2:0] b);
      position_counts_type pc;
      pc.count_a = a; pc.count_c = c; pc.count_g = g;
      pc.count_t = t; pc.count_gap = d; pc.ref_base = b;
      return pc;
   endfunction

   task automatic test_directed();
      localparam logic [23:0] MX = 24'hFFFFFF;
      send_counts(mk(0, 0, 0, 0, 0, pbcm_pkg::BASE_A));           // zero total
      send_counts(mk(0, 0, 0, 0, 0, pbcm_pkg::BASE_GAP));
      send_counts(mk(MX, MX, MX, MX, MX, pbcm_pkg::BASE_A));
      send_counts(mk(MX, MX, MX, MX, MX, 3'd7));
      send_counts(mk(5, 0, 0, 0, 0, pbcm_pkg::BASE_A));           // single class
      send_counts(mk(0, 0, 0, 0, MX, pbcm_pkg::BASE_GAP));
      send_counts(mk(0, 9, 0, 0, 0, pbcm_pkg::BASE_T));
      send_counts(mk(1, 1, 1, 1, 1, pbcm_pkg::BASE_C));
      send_counts(mk(1, 2, 3, 4, 5, pbcm_pkg::BASE_G));
      send_counts(mk(10, 0, 0, 0, 30, pbcm_pkg::BASE_GAP));       // gap reference, mismatch clamps
      send_counts(mk(0, 0, 0, 0, 7, pbcm_pkg::BASE_GAP));
      send_counts(mk(3, 4, 5, 6, 7, 3'd5));                       // out of range reference
      send_counts(mk(3, 4, 5, 6, 7, 3'd6));
      send_counts(mk(MX, 1, 0, 0, 0, pbcm_pkg::BASE_A));          // tiny p
      send_counts(mk(1, MX, 0, 0, 1, pbcm_pkg::BASE_T));
      send_counts(mk(1, 1, 0, 0, 0, pbcm_pkg::BASE_A));
      send_counts(mk(24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA, 24'h123456,
                     pbcm_pkg::BASE_T));
   endtask

   task automatic test_random();
      for (int n = 0; n < 800; n++)
         send_counts(mk(rand_count(), rand_count(), rand_count(), rand_count(),
                        rand_count(), 3'($urandom_range(0, 7))));
   endtask

   task automatic test_full_rate();
      // back to back, receiver always ready
      stall_enable = 1'b0;
      burst_left = 200;
      for (int n = 0; n < 200; n++)
         send_counts(mk(24'($urandom), 24'($urandom_range(0, 50)), rand_count(), 0,
                        24'($urandom), 3'($urandom_range(0, 4))));
      stall_enable = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_full_rate();
      req_tvalid <= 1'b0;
      while (metrics_due.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
